/* design/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high.
`define JKSE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jkse assertion failed");

// Next-cycle implication, sampled on the rising clock, off while reset is high.
`define JKSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jkse assertion failed");

`endif

/* design/jkse_pkg.sv */
// Types, constants and decode functions of the JSON key string extractor.
package jkse_pkg;

   localparam int MAX_KEY_BYTES       = 8;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int MAX_RESULTS         = 5;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 64;

   localparam logic [3:0] KEY_LIMIT = (MAX_KEY_BYTES < 8) ? 4'(MAX_KEY_BYTES) : 4'd8;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_CHARS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPACITY   = 2'd2;

   // Register reset values ("response", eight bytes, 8 KiB)
   localparam logic [63:0] KEY_CHARS_RESET  = 64'h6573_6E6F_7073_6572;
   localparam logic [3:0]  KEY_LENGTH_RESET = 4'd8;
   localparam logic [15:0] CAPACITY_RESET   = 16'd8192;

   // Characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_LOWER_U = 8'h75;

   // Surrogates and UTF-8
   localparam logic [15:0] HIGH_SUR_LO  = 16'hD800;
   localparam logic [15:0] HIGH_SUR_HI  = 16'hDBFF;
   localparam logic [15:0] LOW_SUR_BASE = 16'hDC00;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;
   localparam logic [7:0]  UTF8_CONT    = 8'h80;
   localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
   localparam logic [7:0]  UTF8_LEAD4   = 8'hF0;

   // End reasons
   localparam logic [2:0] REASON_END       = 3'd0;
   localparam logic [2:0] REASON_NO_KEY    = 3'd1;
   localparam logic [2:0] REASON_NO_STRING = 3'd2;
   localparam logic [2:0] REASON_BAD_HEX   = 3'd3;
   localparam logic [2:0] REASON_CAPACITY  = 3'd4;

   typedef enum logic [3:0] {
      PH_SEARCH,
      PH_SKIP,
      PH_CHAR,
      PH_ESC,
      PH_HEX,
      PH_SUR_BS,
      PH_SUR_U,
      PH_SUR_HEX,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       finished;
      logic       success;
      logic [2:0] end_reason;
      logic       run_last;
   } rsp_type;

   // {valid, value} of one hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // Unknown escapes pass through unchanged
   function automatic logic [7:0] escape_byte(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h6E:   r = 8'h0A;
         8'h72:   r = 8'h0D;
         8'h74:   r = 8'h09;
         8'h62:   r = 8'h08;
         8'h66:   r = 8'h0C;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] utf8_length(input logic [20:0] cp, input logic raw);
      logic [2:0] r;
      if (raw || cp < 21'h80) begin
         r = 3'd1;
      end else if (cp < 21'h800) begin
         r = 3'd2;
      end else if (cp < 21'h10000) begin
         r = 3'd3;
      end else begin
         r = 3'd4;
      end
      return r;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic raw,
                                            input logic [1:0] idx);
      logic [7:0] r;
      logic [2:0] len;
      len = utf8_length(cp, raw);
      r = cp[7:0];
      case (len)
         3'd2: begin
            r = (idx == 2'd0) ? (UTF8_LEAD2 | {3'd0, cp[10:6]}) : (UTF8_CONT | {2'd0, cp[5:0]});
         end
         3'd3: begin
            case (idx)
               2'd0:    r = UTF8_LEAD3 | {4'd0, cp[15:12]};
               2'd1:    r = UTF8_CONT | {2'd0, cp[11:6]};
               default: r = UTF8_CONT | {2'd0, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (idx)
               2'd0:    r = UTF8_LEAD4 | {5'd0, cp[20:18]};
               2'd1:    r = UTF8_CONT | {2'd0, cp[17:12]};
               2'd2:    r = UTF8_CONT | {2'd0, cp[11:6]};
               default: r = UTF8_CONT | {2'd0, cp[5:0]};
            endcase
         end
         default: r = cp[7:0];
      endcase
      return r;
   endfunction

   // Output stops once count plus four reaches the capacity
   function automatic logic cap_hit(input logic [31:0] count, input logic [15:0] cap);
      return ({1'b0, count} + 33'd4) >= {17'd0, cap};
   endfunction

endpackage

/* design/json_key_string_extractor_unit.sv */
// Top level of the JSON key string extractor: key search, unescape and UTF-8 output.
//
// Body words enter on req_ (valid/ready), one byte each with a last flag. The block
// finds the quoted key, skips spaces and colons, and unescapes the string value that
// follows. Each decoded UTF-8 byte leaves on rsp_ as a data word; one status word
// (finished, success, end reason) closes the value. run_last flags the last word that a
// given input byte produced. Bytes after the status are dropped until body_last,
// which rearms the search for the next body.
// A byte sits in the input register, is decoded into up to five words, and the words
// drain from the output register one per cycle while rsp_ready is high. A byte with
// several words holds the next byte in the input register until its last word leaves;
// bytes that yield one word or none flow at one per cycle while rsp_ready is high.
// When rsp_ready is low, the output words hold and req_ready drops as soon as the
// input register is occupied. Reset (synchronous) empties both registers, rearms
// the search and loads the default key, key length and capacity.
// csr_ writes are registered and are meant for idle periods only.
module json_key_string_extractor_unit #(
   parameter int COUNT_WIDTH = jkse_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  jkse_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output jkse_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_we,
   input  logic [jkse_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [jkse_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   // Configuration
   logic [63:0] key_chars_ff;
   logic [3:0]  key_length_ff;
   logic [15:0] capacity_ff;

   // Input register
   logic              in_valid_ff;
   jkse_pkg::req_type in_ff;

   // Body state
   jkse_pkg::phase_type    phase_ff, phase_in;
   logic [3:0]             match_ff, match_in;
   logic [15:0]            acc_ff, acc_in;
   logic [1:0]             digits_ff, digits_in;
   logic [15:0]            pending_ff, pending_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   // Output register
   jkse_pkg::rsp_type buf_ff [jkse_pkg::MAX_RESULTS];
   logic [2:0]        buf_count_ff;

   logic pop, fire;

   // Decode
   jkse_pkg::phase_type stage;
   logic [7:0]  c;
   logic        last;
   logic [3:0]  key_len_eff, match_next, key_idx;
   logic [7:0]  want;
   logic [4:0]  hex;
   logic [15:0] acc_new;
   logic [20:0] sur_cp;
   logic        a_en;
   logic [15:0] a_cp;
   logic [2:0]  b_len;
   logic [20:0] b_cp;
   logic        b_raw;
   logic        st_en, st_success;
   logic [2:0]  st_reason;
   logic [2:0]  off_b, n_items;
   jkse_pkg::rsp_type items [jkse_pkg::MAX_RESULTS];

   assign c    = in_ff.body_byte;
   assign last = in_ff.body_last;

   always_comb begin
      if (key_length_ff == 4'd0) begin
         key_len_eff = 4'd1;
      end else if (key_length_ff > jkse_pkg::KEY_LIMIT) begin
         key_len_eff = jkse_pkg::KEY_LIMIT;
      end else begin
         key_len_eff = key_length_ff;
      end
   end

   assign match_next = match_ff + 4'd1;
   assign key_idx    = match_ff - 4'd1;
   assign want       = (match_ff == 4'd0 || match_ff > key_len_eff) ? jkse_pkg::CH_QUOTE
                       : key_chars_ff[{key_idx[2:0], 3'b000} +: 8];
   assign hex        = jkse_pkg::hex_value(c);
   assign acc_new    = {acc_ff[11:0], hex[3:0]};
   assign sur_cp     = jkse_pkg::SUPP_BASE + {1'b0, pending_ff[9:0], 10'd0}
                       + {5'd0, acc_new} - {5'd0, jkse_pkg::LOW_SUR_BASE};

   always_comb begin
      phase_in   = phase_ff;
      match_in   = match_ff;
      acc_in     = acc_ff;
      digits_in  = digits_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      stage      = phase_ff;
      a_en       = 1'b0;
      a_cp       = pending_ff;
      b_len      = 3'd0;
      b_cp       = 21'd0;
      b_raw      = 1'b0;
      st_en      = 1'b0;
      st_success = 1'b0;
      st_reason  = jkse_pkg::REASON_END;

      if (phase_ff != jkse_pkg::PH_DONE && c != jkse_pkg::CH_NUL) begin
         // Flush a held high surrogate that is not followed by a second \u escape
         if (phase_ff == jkse_pkg::PH_SUR_BS && c != jkse_pkg::CH_BSLASH) begin
            a_en     = 1'b1;
            count_in = count_in + COUNT_WIDTH'(3);
            stage    = jkse_pkg::PH_CHAR;
         end else if (phase_ff == jkse_pkg::PH_SUR_U && c != jkse_pkg::CH_LOWER_U) begin
            a_en     = 1'b1;
            count_in = count_in + COUNT_WIDTH'(3);
            stage    = jkse_pkg::PH_ESC;
         end

         if (a_en && jkse_pkg::cap_hit(32'(count_in), capacity_ff)) begin
            st_en      = 1'b1;
            st_success = 1'b1;
            st_reason  = jkse_pkg::REASON_CAPACITY;
         end else begin
            unique case (stage)
               jkse_pkg::PH_SEARCH: begin
                  if (c == want) begin
                     if (match_next >= key_len_eff + 4'd2) begin
                        phase_in = jkse_pkg::PH_SKIP;
                        match_in = 4'd0;
                     end else begin
                        match_in = match_next;
                     end
                  end else begin
                     match_in = (c == jkse_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
                  end
               end
               jkse_pkg::PH_SKIP: begin
                  if (c == jkse_pkg::CH_QUOTE) begin
                     phase_in = jkse_pkg::PH_CHAR;
                     if (jkse_pkg::cap_hit(32'(count_in), capacity_ff)) begin
                        st_en      = 1'b1;
                        st_success = 1'b1;
                        st_reason  = jkse_pkg::REASON_CAPACITY;
                     end
                  end else if (c != jkse_pkg::CH_SPACE && c != jkse_pkg::CH_COLON) begin
                     st_en     = 1'b1;
                     st_reason = jkse_pkg::REASON_NO_STRING;
                  end
               end
               jkse_pkg::PH_CHAR: begin
                  phase_in = jkse_pkg::PH_CHAR;
                  if (c == jkse_pkg::CH_QUOTE) begin
                     st_en      = 1'b1;
                     st_success = 1'b1;
                  end else if (c == jkse_pkg::CH_BSLASH) begin
                     phase_in = jkse_pkg::PH_ESC;
                  end else begin
                     b_len = 3'd1;
                     b_cp  = {13'd0, c};
                     b_raw = 1'b1;
                  end
               end
               jkse_pkg::PH_ESC: begin
                  if (c == jkse_pkg::CH_LOWER_U) begin
                     phase_in  = jkse_pkg::PH_HEX;
                     acc_in    = 16'd0;
                     digits_in = 2'd0;
                  end else begin
                     phase_in = jkse_pkg::PH_CHAR;
                     b_len    = 3'd1;
                     b_cp     = {13'd0, jkse_pkg::escape_byte(c)};
                     b_raw    = 1'b1;
                  end
               end
               jkse_pkg::PH_HEX: begin
                  if (!hex[4]) begin
                     st_en      = 1'b1;
                     st_success = (count_in != '0);
                     st_reason  = jkse_pkg::REASON_BAD_HEX;
                  end else begin
                     acc_in    = acc_new;
                     digits_in = digits_ff + 2'd1;
                     if (digits_ff == 2'd3) begin
                        if (acc_new >= jkse_pkg::HIGH_SUR_LO
                            && acc_new <= jkse_pkg::HIGH_SUR_HI) begin
                           pending_in = acc_new;
                           phase_in   = jkse_pkg::PH_SUR_BS;
                        end else begin
                           phase_in = jkse_pkg::PH_CHAR;
                           b_cp     = {5'd0, acc_new};
                           b_len    = jkse_pkg::utf8_length({5'd0, acc_new}, 1'b0);
                        end
                     end
                  end
               end
               jkse_pkg::PH_SUR_BS: begin
                  phase_in = jkse_pkg::PH_SUR_U;
               end
               jkse_pkg::PH_SUR_U: begin
                  phase_in  = jkse_pkg::PH_SUR_HEX;
                  acc_in    = 16'd0;
                  digits_in = 2'd0;
               end
               jkse_pkg::PH_SUR_HEX: begin
                  if (!hex[4]) begin
                     a_en       = 1'b1;
                     count_in   = count_in + COUNT_WIDTH'(3);
                     st_en      = 1'b1;
                     st_success = 1'b1;
                     st_reason  = jkse_pkg::cap_hit(32'(count_in), capacity_ff)
                                  ? jkse_pkg::REASON_CAPACITY : jkse_pkg::REASON_BAD_HEX;
                  end else begin
                     acc_in    = acc_new;
                     digits_in = digits_ff + 2'd1;
                     if (digits_ff == 2'd3) begin
                        phase_in = jkse_pkg::PH_CHAR;
                        b_cp     = sur_cp;
                        b_len    = jkse_pkg::utf8_length(sur_cp, 1'b0);
                     end
                  end
               end
               default: ;
            endcase

            // Completed character: count it, then check room for another
            if (b_len != 3'd0) begin
               count_in = count_in + COUNT_WIDTH'(b_len);
               if (jkse_pkg::cap_hit(32'(count_in), capacity_ff)) begin
                  st_en      = 1'b1;
                  st_success = 1'b1;
                  st_reason  = jkse_pkg::REASON_CAPACITY;
               end
            end
         end
      end

      // Body end: close the value from wherever decoding stands
      if (phase_ff != jkse_pkg::PH_DONE && (c == jkse_pkg::CH_NUL || last) && !st_en) begin
         st_en = 1'b1;
         a_cp  = pending_in;
         unique case (phase_in) inside
            jkse_pkg::PH_SEARCH: begin
               st_reason = jkse_pkg::REASON_NO_KEY;
            end
            jkse_pkg::PH_SKIP: begin
               st_reason = jkse_pkg::REASON_NO_STRING;
            end
            jkse_pkg::PH_HEX: begin
               st_success = (count_in != '0);
               st_reason  = jkse_pkg::REASON_BAD_HEX;
            end
            jkse_pkg::PH_SUR_BS, jkse_pkg::PH_SUR_U: begin
               a_en       = 1'b1;
               count_in   = count_in + COUNT_WIDTH'(3);
               st_success = 1'b1;
               st_reason  = jkse_pkg::cap_hit(32'(count_in), capacity_ff)
                            ? jkse_pkg::REASON_CAPACITY : jkse_pkg::REASON_END;
            end
            jkse_pkg::PH_SUR_HEX: begin
               a_en       = 1'b1;
               count_in   = count_in + COUNT_WIDTH'(3);
               st_success = 1'b1;
               st_reason  = jkse_pkg::cap_hit(32'(count_in), capacity_ff)
                            ? jkse_pkg::REASON_CAPACITY : jkse_pkg::REASON_BAD_HEX;
            end
            default: begin
               st_success = 1'b1;
            end
         endcase
      end

      if (st_en) begin
         phase_in = jkse_pkg::PH_DONE;
      end

      // Rearm for the next body
      if (last) begin
         phase_in   = jkse_pkg::PH_SEARCH;
         match_in   = 4'd0;
         acc_in     = 16'd0;
         digits_in  = 2'd0;
         pending_in = 16'd0;
         count_in   = '0;
      end
   end

   // Lay out the words: held surrogate bytes, then the character, then the status
   assign off_b   = a_en ? 3'd3 : 3'd0;
   assign n_items = off_b + b_len + {2'd0, st_en};

   always_comb begin
      for (int j = 0; j < jkse_pkg::MAX_RESULTS; j++) begin
         items[j] = '0;
         if (3'(j) < off_b) begin
            items[j].out_byte   = jkse_pkg::utf8_byte({5'd0, a_cp}, 1'b0, 2'(j));
            items[j].byte_valid = 1'b1;
         end else if (3'(j) < off_b + b_len) begin
            items[j].out_byte   = jkse_pkg::utf8_byte(b_cp, b_raw, 2'(3'(j) - off_b));
            items[j].byte_valid = 1'b1;
         end else begin
            items[j].finished   = 1'b1;
            items[j].success    = st_success;
            items[j].end_reason = st_reason;
         end
         items[j].run_last = (3'(j) + 3'd1 == n_items);
      end
   end

   // Handshakes
   assign rsp_valid = (buf_count_ff != 3'd0);
   assign rsp_data  = buf_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign fire      = in_valid_ff && (buf_count_ff == 3'd0 || (buf_count_ff == 3'd1 && pop));
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_chars_ff  <= jkse_pkg::KEY_CHARS_RESET;
         key_length_ff <= jkse_pkg::KEY_LENGTH_RESET;
         capacity_ff   <= jkse_pkg::CAPACITY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            jkse_pkg::CSR_KEY_CHARS:  key_chars_ff  <= csr_wdata;
            jkse_pkg::CSR_KEY_LENGTH: key_length_ff <= csr_wdata[3:0];
            jkse_pkg::CSR_CAPACITY:   capacity_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jkse_pkg::PH_SEARCH;
      end else if (fire) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff   <= 4'd0;
         acc_ff     <= 16'd0;
         digits_ff  <= 2'd0;
         pending_ff <= 16'd0;
         count_ff   <= '0;
      end else if (fire) begin
         match_ff   <= match_in;
         acc_ff     <= acc_in;
         digits_ff  <= digits_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_count_ff <= 3'd0;
      end else if (fire) begin
         buf_count_ff <= n_items;
      end else if (pop) begin
         buf_count_ff <= buf_count_ff - 3'd1;
      end
   end

   // Load a fresh run of words, or advance the queue by one
   always_ff @(posedge clock) begin
      if (fire) begin
         buf_ff <= items;
      end else if (pop) begin
         for (int k = 0; k < jkse_pkg::MAX_RESULTS - 1; k++) begin
            buf_ff[k] <= buf_ff[k + 1];
         end
      end
   end

endmodule

/* design/jkse_checker.sv */
// Port-level checker of the JSON key string extractor, bound to the top level.
`include "assert_macros.svh"

module jkse_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input jkse_pkg::rsp_type rsp_data
);

   logic is_status, is_data, data_clean;

   assign is_status  = rsp_valid && rsp_data.finished;
   assign is_data    = rsp_valid && rsp_data.byte_valid;
   assign data_clean = !rsp_data.success && rsp_data.end_reason == jkse_pkg::REASON_END;

   `JKSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A word is either a data byte or the status, never both or neither
   `JKSE_ASSERT_NOW(a_word_kind, rsp_valid, rsp_data.byte_valid != rsp_data.finished)

   // The status always closes the run of its input byte
   `JKSE_ASSERT_NOW(a_status_last, is_status, rsp_data.run_last && rsp_data.out_byte == 8'd0)

   `JKSE_ASSERT_NOW(a_data_clean, is_data, data_clean)

   `JKSE_ASSERT_NOW(a_reason_range, is_status, rsp_data.end_reason <= jkse_pkg::REASON_CAPACITY)

endmodule

bind json_key_string_extractor_unit jkse_checker u_jkse_checker (.*);

/* bench/tb.sv */
// Self-checking bench for the JSON key string extractor: directed bodies, then random traffic.
`timescale 1ns / 1ps

module tb;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BYTES_PER_PHASE = 6;
   localparam logic [63:0] KEY_K = 64'hFFFF_FFFF_FFFF_FF6B;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   jkse_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   jkse_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [jkse_pkg::CSR_INDEX_WIDTH-1:0] csr_index = jkse_pkg::CSR_KEY_CHARS;
   logic [jkse_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   json_key_string_extractor_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Extractor state mirrored by the bench
   logic [63:0] m_key;
   logic [3:0] m_key_len;
   logic [15:0] m_cap;
   jkse_pkg::phase_type m_phase;
   int unsigned m_match;
   logic [15:0] m_hex;
   int unsigned m_hex_n;
   logic [15:0] m_high;
   logic [15:0] m_count;

   jkse_pkg::rsp_type step_words[$];
   jkse_pkg::rsp_type decoded_words[$];
   jkse_pkg::rsp_type want_word;
   logic [7:0] body_q[$];

   int mismatch_count = 0;
   int stall_cycles = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- word decoder ----------------

   function automatic void push_word(logic [7:0] b, logic v, logic f, logic s, logic [2:0] r);
      jkse_pkg::rsp_type w;
      if (step_words.size() >= jkse_pkg::MAX_RESULTS) return;
      w.out_byte = b;
      w.byte_valid = v;
      w.finished = f;
      w.success = s;
      w.end_reason = r;
      w.run_last = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic logic at_capacity();
      return (32'(m_count) + 32'd4) >= 32'(m_cap);
   endfunction

   function automatic void emit_data(logic [7:0] b);
      if ((32'(m_count) + 32'd1) >= 32'(m_cap)) return;
      push_word(b, 1'b1, 1'b0, 1'b0, jkse_pkg::REASON_END);
      m_count = m_count + 16'd1;
   endfunction

   function automatic void emit_status(logic s, logic [2:0] r);
      push_word(8'h00, 1'b0, 1'b1, s, r);
      m_phase = jkse_pkg::PH_DONE;
   endfunction

   function automatic void emit_code_point(logic [31:0] cp);
      if (cp < 32'h80) begin
         emit_data(cp[7:0]);
      end else if (cp < 32'h800) begin
         emit_data(jkse_pkg::UTF8_LEAD2 | 8'(cp >> 6));
         emit_data(jkse_pkg::UTF8_CONT | 8'(cp & 32'h3F));
      end else if (cp < 32'h10000) begin
         emit_data(jkse_pkg::UTF8_LEAD3 | 8'(cp >> 12));
         emit_data(jkse_pkg::UTF8_CONT | 8'((cp >> 6) & 32'h3F));
         emit_data(jkse_pkg::UTF8_CONT | 8'(cp & 32'h3F));
      end else begin
         emit_data(jkse_pkg::UTF8_LEAD4 | 8'(cp >> 18));
         emit_data(jkse_pkg::UTF8_CONT | 8'((cp >> 12) & 32'h3F));
         emit_data(jkse_pkg::UTF8_CONT | 8'((cp >> 6) & 32'h3F));
         emit_data(jkse_pkg::UTF8_CONT | 8'(cp & 32'h3F));
      end
   endfunction

   function automatic void close_char();
      if (at_capacity()) emit_status(1'b1, jkse_pkg::REASON_CAPACITY);
   endfunction

   function automatic int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic int unsigned eff_key_len(logic [3:0] l);
      if (l < 4'd1) return 1;
      if (l > jkse_pkg::KEY_LIMIT) return 32'(jkse_pkg::KEY_LIMIT);
      return 32'(l);
   endfunction

   function automatic void value_char(logic [7:0] c);
      if (c == jkse_pkg::CH_QUOTE) begin
         emit_status(1'b1, jkse_pkg::REASON_END);
      end else if (c == jkse_pkg::CH_BSLASH) begin
         m_phase = jkse_pkg::PH_ESC;
      end else begin
         emit_data(c);
         close_char();
      end
   endfunction

   function automatic void escape_char(logic [7:0] e);
      logic [7:0] b;
      if (e == jkse_pkg::CH_LOWER_U) begin
         m_phase = jkse_pkg::PH_HEX;
         m_hex = '0;
         m_hex_n = 0;
         return;
      end
      case (e)
         "n":     b = 8'h0A;
         "r":     b = 8'h0D;
         "t":     b = 8'h09;
         "b":     b = 8'h08;
         "f":     b = 8'h0C;
         default: b = e;
      endcase
      m_phase = jkse_pkg::PH_CHAR;
      emit_data(b);
      close_char();
   endfunction

   function automatic void finish_body();
      case (m_phase) inside
         jkse_pkg::PH_SEARCH: emit_status(1'b0, jkse_pkg::REASON_NO_KEY);
         jkse_pkg::PH_SKIP:   emit_status(1'b0, jkse_pkg::REASON_NO_STRING);
         jkse_pkg::PH_CHAR, jkse_pkg::PH_ESC: emit_status(1'b1, jkse_pkg::REASON_END);
         jkse_pkg::PH_HEX:    emit_status(m_count != 16'd0, jkse_pkg::REASON_BAD_HEX);
         jkse_pkg::PH_SUR_BS, jkse_pkg::PH_SUR_U: begin
            emit_code_point(32'(m_high));
            emit_status(1'b1, at_capacity() ? jkse_pkg::REASON_CAPACITY
                                            : jkse_pkg::REASON_END);
         end
         jkse_pkg::PH_SUR_HEX: begin
            emit_code_point(32'(m_high));
            emit_status(1'b1, at_capacity() ? jkse_pkg::REASON_CAPACITY
                                            : jkse_pkg::REASON_BAD_HEX);
         end
         default: ;
      endcase
   endfunction

   function automatic void decode_char(logic [7:0] c);
      int h;
      int unsigned klen;
      logic [7:0] want;
      logic [31:0] cp;
      case (m_phase)
         jkse_pkg::PH_SEARCH: begin
            klen = eff_key_len(m_key_len);
            if (m_match == 0 || m_match > klen) want = jkse_pkg::CH_QUOTE;
            else want = 8'(m_key >> (8 * (m_match - 1)));
            if (c == want) begin
               m_match++;
               if (m_match >= klen + 2) begin
                  m_phase = jkse_pkg::PH_SKIP;
                  m_match = 0;
               end
            end else begin
               m_match = (c == jkse_pkg::CH_QUOTE) ? 1 : 0;
            end
         end
         jkse_pkg::PH_SKIP: begin
            if (c == jkse_pkg::CH_QUOTE) begin
               m_phase = jkse_pkg::PH_CHAR;
               close_char();
            end else if (c != jkse_pkg::CH_SPACE && c != jkse_pkg::CH_COLON) begin
               emit_status(1'b0, jkse_pkg::REASON_NO_STRING);
            end
         end
         jkse_pkg::PH_CHAR: value_char(c);
         jkse_pkg::PH_ESC:  escape_char(c);
         jkse_pkg::PH_HEX: begin
            h = hex_nibble(c);
            if (h < 0) begin
               emit_status(m_count != 16'd0, jkse_pkg::REASON_BAD_HEX);
            end else begin
               m_hex = {m_hex[11:0], 4'(h)};
               m_hex_n++;
               if (m_hex_n >= 4) begin
                  m_hex_n = 0;
                  if (m_hex >= jkse_pkg::HIGH_SUR_LO && m_hex <= jkse_pkg::HIGH_SUR_HI) begin
                     m_high = m_hex;
                     m_phase = jkse_pkg::PH_SUR_BS;
                  end else begin
                     m_phase = jkse_pkg::PH_CHAR;
                     emit_code_point(32'(m_hex));
                     close_char();
                  end
               end
            end
         end
         jkse_pkg::PH_SUR_BS: begin
            if (c == jkse_pkg::CH_BSLASH) begin
               m_phase = jkse_pkg::PH_SUR_U;
            end else begin
               // flush the lone surrogate, then decode this byte as usual
               m_phase = jkse_pkg::PH_CHAR;
               emit_code_point(32'(m_high));
               close_char();
               if (m_phase != jkse_pkg::PH_DONE) value_char(c);
            end
         end
         jkse_pkg::PH_SUR_U: begin
            if (c == jkse_pkg::CH_LOWER_U) begin
               m_phase = jkse_pkg::PH_SUR_HEX;
               m_hex = '0;
               m_hex_n = 0;
            end else begin
               m_phase = jkse_pkg::PH_ESC;
               emit_code_point(32'(m_high));
               close_char();
               if (m_phase != jkse_pkg::PH_DONE) escape_char(c);
            end
         end
         jkse_pkg::PH_SUR_HEX: begin
            h = hex_nibble(c);
            if (h < 0) begin
               emit_code_point(32'(m_high));
               emit_status(1'b1, at_capacity() ? jkse_pkg::REASON_CAPACITY
                                               : jkse_pkg::REASON_BAD_HEX);
            end else begin
               m_hex = {m_hex[11:0], 4'(h)};
               m_hex_n++;
               if (m_hex_n >= 4) begin
                  // combine whatever the second escape holds
                  cp = 32'(jkse_pkg::SUPP_BASE)
                     + ((32'(m_high) - 32'(jkse_pkg::HIGH_SUR_LO)) << 10)
                     + (32'(m_hex) - 32'(jkse_pkg::LOW_SUR_BASE));
                  m_hex_n = 0;
                  m_phase = jkse_pkg::PH_CHAR;
                  emit_code_point(cp);
                  close_char();
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void rearm_body();
      m_phase = jkse_pkg::PH_SEARCH;
      m_match = 0;
      m_hex = '0;
      m_hex_n = 0;
      m_high = '0;
      m_count = '0;
   endfunction

   function automatic void decode_body_byte(jkse_pkg::req_type r);
      jkse_pkg::rsp_type w;
      step_words.delete();
      if (m_phase != jkse_pkg::PH_DONE) begin
         if (r.body_byte == jkse_pkg::CH_NUL) finish_body();
         else decode_char(r.body_byte);
         if (r.body_last && m_phase != jkse_pkg::PH_DONE) finish_body();
      end
      if (r.body_last) rearm_body();
      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.run_last = 1'b1;
         step_words.push_back(w);
      end
      foreach (step_words[i]) decoded_words.push_back(step_words[i]);
   endfunction

   // ---------------- checking ----------------

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_words.size() == 0) begin
               $error("unexpected result word: out_byte %0h finished %0b",
                      rsp_data.out_byte, rsp_data.finished);
               mismatch_count++;
            end else begin
               want_word = decoded_words.pop_front();
               check_field("out_byte", want_word.out_byte, rsp_data.out_byte);
               check_field("byte_valid", want_word.byte_valid, rsp_data.byte_valid);
               check_field("finished", want_word.finished, rsp_data.finished);
               check_field("success", want_word.success, rsp_data.success);
               check_field("end_reason", want_word.end_reason, rsp_data.end_reason);
               check_field("run_last", want_word.run_last, rsp_data.run_last);
            end
         end
         if (req_valid && req_ready) decode_body_byte(req_data);
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------- drivers ----------------

   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{body_byte: b, body_last: last};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_body();
      for (int i = 0; i < body_q.size(); i++) send_word(body_q[i], i == body_q.size() - 1);
      body_q.delete();
   endtask

   function automatic void add_text(string s);
      foreach (s[i]) body_q.push_back(s[i]);
   endfunction

   task automatic send_text(input string s);
      add_text(s);
      send_body();
   endtask

   // Hold off the sender until every predicted word is out, then let the pipe settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input logic [63:0] key, input logic [63:0] len_word,
                             input logic [63:0] cap_word);
      csr_we <= 1'b1;
      csr_index <= jkse_pkg::CSR_KEY_CHARS;
      csr_wdata <= key;
      @(posedge clock);
      csr_index <= jkse_pkg::CSR_KEY_LENGTH;
      csr_wdata <= len_word;
      @(posedge clock);
      csr_index <= jkse_pkg::CSR_CAPACITY;
      csr_wdata <= cap_word;
      @(posedge clock);
      csr_we <= 1'b0;
      m_key = key;
      m_key_len = len_word[3:0];
      m_cap = cap_word[15:0];
   endtask

   // ---------------- random body builder ----------------

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return "0" + 8'(v);
      return ($urandom_range(1) ? "a" : "A") + 8'(v) - 8'd10;
   endfunction

   function automatic void add_hex4(logic [15:0] v);
      for (int i = 3; i >= 0; i--) body_q.push_back(hex_char(v[4*i +: 4]));
   endfunction

   function automatic void add_escape(logic [7:0] e);
      body_q.push_back(jkse_pkg::CH_BSLASH);
      body_q.push_back(e);
   endfunction

   function automatic logic [7:0] noise_byte(logic [63:0] key);
      int k;
      k = $urandom_range(15);
      if (k < 2) return jkse_pkg::CH_QUOTE;
      if (k == 2) return jkse_pkg::CH_BSLASH;
      if (k < 5) return key[7:0];
      if (k == 5) return jkse_pkg::CH_NUL;
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic void add_value_piece();
      int k;
      logic [7:0] b;
      k = $urandom_range(99);
      if (k < 35) begin
         b = 8'($urandom_range(1, 255));
         if (b == jkse_pkg::CH_QUOTE || b == jkse_pkg::CH_BSLASH) b = "x";
         body_q.push_back(b);
      end else if (k < 50) begin
         case ($urandom_range(7))
            0: b = "n";
            1: b = "r";
            2: b = "t";
            3: b = "b";
            4: b = "f";
            5: b = "/";
            6: b = jkse_pkg::CH_BSLASH;
            default: b = jkse_pkg::CH_QUOTE;
         endcase
         add_escape(b);
      end else if (k < 58) begin
         b = 8'($urandom_range(1, 255));
         if (b == jkse_pkg::CH_LOWER_U) b = "q";
         add_escape(b);
      end else if (k < 75) begin
         add_escape(jkse_pkg::CH_LOWER_U);
         add_hex4(16'($urandom));
      end else if (k < 88) begin
         add_escape(jkse_pkg::CH_LOWER_U);
         add_hex4(jkse_pkg::HIGH_SUR_LO + 16'($urandom_range(0, 16'h3FF)));
         add_escape(jkse_pkg::CH_LOWER_U);
         if ($urandom_range(9) == 0) add_hex4(16'($urandom));
         else add_hex4(jkse_pkg::LOW_SUR_BASE + 16'($urandom_range(0, 16'h3FF)));
      end else if (k < 95) begin
         add_escape(jkse_pkg::CH_LOWER_U);
         add_hex4(jkse_pkg::HIGH_SUR_LO + 16'($urandom_range(0, 16'h3FF)));
      end else begin
         add_escape(jkse_pkg::CH_LOWER_U);
         repeat ($urandom_range(0, 3)) body_q.push_back(hex_char(4'($urandom)));
         b = 8'($urandom_range(1, 255));
         if (hex_nibble(b) >= 0) b = "g";
         body_q.push_back(b);
      end
   endfunction

   function automatic void build_random_body(logic [63:0] key, int unsigned klen);
      int kind;
      int unsigned keep;
      kind = $urandom_range(99);
      if (kind >= 85) begin
         repeat ($urandom_range(1, 12)) body_q.push_back(noise_byte(key));
         return;
      end
      repeat ($urandom_range(0, 2)) body_q.push_back(noise_byte(key));
      body_q.push_back(jkse_pkg::CH_QUOTE);
      for (int i = 0; i < klen; i++) body_q.push_back(key[8*i +: 8]);
      body_q.push_back(jkse_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 3)) begin
         body_q.push_back($urandom_range(1) ? jkse_pkg::CH_SPACE : jkse_pkg::CH_COLON);
      end
      if ($urandom_range(9) == 0) body_q.push_back(noise_byte(key));
      else body_q.push_back(jkse_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 5)) add_value_piece();
      if ($urandom_range(9) != 0) body_q.push_back(jkse_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 2)) body_q.push_back(noise_byte(key));
      // cut the body short at a random point
      if (kind >= 70) begin
         keep = $urandom_range(1, body_q.size());
         while (body_q.size() > keep) void'(body_q.pop_back());
      end
   endfunction

   // ---------------- tests ----------------

   task automatic test_default_key();
      send_text("\"response\":\"ok\"");
   endtask

   task automatic test_escapes();
      drain_results();
      set_config(KEY_K, 64'd1, 64'd65535);
      add_text("\"k\":\"\\n\\/\\q");
      body_q.push_back(8'hFF);
      add_text("\\\"\"");
      send_body();
   endtask

   task automatic test_unicode();
      send_text("\"k\":\"\\u00e9\\u20AC");
   endtask

   task automatic test_surrogates();
      send_text("\"k\":\"\\uD83D\\uDE00");
      send_text("\"k\":\"\\uD800\\n");
   endtask

   task automatic test_bad_hex();
      send_text("\"k\":\"\\u1x");
   endtask

   task automatic test_body_end();
      send_text("\"k\":");
      add_text("\"k\":\"a");
      body_q.push_back(jkse_pkg::CH_NUL);
      add_text("b");
      send_body();
      send_text("\"k\":\"\\");
   endtask

   task automatic test_capacity();
      drain_results();
      set_config(KEY_K, 64'd1, 64'd4);
      send_text("\"k\":\"a\"");
      drain_results();
      set_config(KEY_K, 64'd1, 64'd7);
      send_text("\"k\":\"\\uD800y");
   endtask

   task automatic test_key_length();
      drain_results();
      set_config(KEY_K, 64'd0, 64'd65535);
      send_text("\"k\":\"v");
      drain_results();
      set_config(64'h6867_6665_6463_6261, 64'd15, 64'd65535);
      send_text("\"abcdefgh\":\"v");
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [3:0] len, input logic [15:0] cap);
      logic [63:0] key;
      logic [63:0] len_word;
      logic [63:0] cap_word;
      int sent;
      drain_results();
      key = {$urandom, $urandom};
      for (int i = 0; i < 8; i++) begin
         if (key[8*i +: 8] == jkse_pkg::CH_NUL || key[8*i +: 8] == jkse_pkg::CH_QUOTE) begin
            key[8*i +: 8] = "k";
         end
      end
      len_word = {$urandom, $urandom};
      len_word[3:0] = len;
      cap_word = {$urandom, $urandom};
      cap_word[15:0] = cap;
      set_config(key, len_word, cap_word);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < RANDOM_BYTES_PER_PHASE) begin
         build_random_body(key, eff_key_len(len));
         sent += body_q.size();
         send_body();
         if ($urandom_range(7) == 0) drain_results();
      end
   endtask

   initial begin
      m_key = jkse_pkg::KEY_CHARS_RESET;
      m_key_len = jkse_pkg::KEY_LENGTH_RESET;
      m_cap = jkse_pkg::CAPACITY_RESET;
      rearm_body();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_default_key();
      test_escapes();
      test_unicode();
      test_surrogates();
      test_bad_hex();
      test_body_end();
      test_capacity();
      test_key_length();

      test_random_traffic(0, 0, 4'd1, 16'hFFFF);
      test_random_traffic(58, 0, 4'd3, 16'($urandom_range(5, 24)));
      test_random_traffic(0, 58, 4'($urandom_range(9, 15)), 16'($urandom_range(5, 40)));
      test_random_traffic(22, 22, 4'd0, 16'($urandom_range(5, 65535)));

      drain_results();
      if (mismatch_count == 0 && decoded_words.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
